/* sv/segment_intersection_test_core_defines.svh */
// Assertion macros for the segment intersection test core
`ifndef SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* sv/sit_pkg.sv */
// Types and constants for the segment intersection test core
package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;
    localparam int MAG_W  = DET_W - 1;
    localparam int CLOSE_W = FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [COORD_BITS-1:0] b1_x;
        logic signed [COORD_BITS-1:0] b1_y;
        logic signed [COORD_BITS-1:0] b2_x;
        logic signed [COORD_BITS-1:0] b2_y;
    } sit_pair_t;

    typedef struct packed {
        logic               hit;
        logic [CLOSE_W-1:0] closeness;
    } sit_result_t;

endpackage

/* sv/segment_intersection_test_core.sv */
// Segment intersection test core: pipelined parametric segment-pair hit test
//
// Takes one segment pair word per cycle and returns one result word per pair, in order.
// Stages are differences, products, cross products, sign normalisation and range
// test, then a restoring divider with one quotient bit per stage forming ua = na/d
// as Q1.16. Stall on the result side holds the whole pipeline; pair_stall is high
// only while a finished word waits to be taken.
`include "segment_intersection_test_core_defines.svh"

module segment_intersection_test_core
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_stall,
    input  sit_pair_t   pair,
    output logic        result_valid,
    input  logic        result_stall,
    output sit_result_t result
);

    localparam int NDIV = FRAC_BITS + 1;

    logic adv;
    assign adv        = !(result_valid && result_stall);
    assign pair_stall = !adv;

    // stage 1: differences
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg, ox_reg, oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pair_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adx_reg <= DIFF_W'(pair.a2_x) - DIFF_W'(pair.a1_x);
            ady_reg <= DIFF_W'(pair.a2_y) - DIFF_W'(pair.a1_y);
            bdx_reg <= DIFF_W'(pair.b2_x) - DIFF_W'(pair.b1_x);
            bdy_reg <= DIFF_W'(pair.b2_y) - DIFF_W'(pair.b1_y);
            ox_reg  <= DIFF_W'(pair.a1_x) - DIFF_W'(pair.b1_x);
            oy_reg  <= DIFF_W'(pair.a1_y) - DIFF_W'(pair.b1_y);
        end
    end

    // stage 2: products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] p_d0_reg, p_d1_reg, p_a0_reg, p_a1_reg, p_b0_reg, p_b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_d0_reg <= PROD_W'(bdy_reg) * PROD_W'(adx_reg);
            p_d1_reg <= PROD_W'(bdx_reg) * PROD_W'(ady_reg);
            p_a0_reg <= PROD_W'(bdx_reg) * PROD_W'(oy_reg);
            p_a1_reg <= PROD_W'(bdy_reg) * PROD_W'(ox_reg);
            p_b0_reg <= PROD_W'(adx_reg) * PROD_W'(oy_reg);
            p_b1_reg <= PROD_W'(ady_reg) * PROD_W'(ox_reg);
        end
    end

    // stage 3: denominator and numerators
    logic                    s3_valid_reg;
    logic signed [DET_W-1:0] d_reg, na_reg, nb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg  <= DET_W'(p_d0_reg) - DET_W'(p_d1_reg);
            na_reg <= DET_W'(p_a0_reg) - DET_W'(p_a1_reg);
            nb_reg <= DET_W'(p_b0_reg) - DET_W'(p_b1_reg);
        end
    end

    // stage 4: sign normalisation and range test
    logic                    s4_valid_reg;
    logic                    s4_hit_reg, s4_hit_next;
    logic        [MAG_W-1:0] s4_n_reg, s4_n_next;
    logic        [MAG_W-1:0] s4_d_reg, s4_d_next;
    logic signed [DET_W-1:0] d_abs, na_n, nb_n;

    always_comb
    begin
        d_abs       = d_reg[DET_W-1] ? -d_reg  : d_reg;
        na_n        = d_reg[DET_W-1] ? -na_reg : na_reg;
        nb_n        = d_reg[DET_W-1] ? -nb_reg : nb_reg;
        s4_hit_next = (d_reg != '0) && !na_n[DET_W-1] && !nb_n[DET_W-1]
                      && (na_n <= d_abs) && (nb_n <= d_abs);
        s4_n_next   = na_n[MAG_W-1:0];
        s4_d_next   = d_abs[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_hit_reg <= s4_hit_next;
            s4_n_reg   <= s4_n_next;
            s4_d_reg   <= s4_d_next;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    logic [NDIV-1:0]    div_valid_reg;
    logic [NDIV-1:0]    div_hit_reg;
    logic [MAG_W-1:0]   div_rem_reg [NDIV];
    logic [MAG_W-1:0]   div_d_reg   [NDIV];
    logic [CLOSE_W-1:0] div_q_reg   [NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
        end
        else if (adv)
        begin
            div_valid_reg <= {div_valid_reg[NDIV-2:0], s4_valid_reg};
        end
    end

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic [MAG_W:0]     trial;
        logic               ge;
        logic [MAG_W-1:0]   d_in;
        logic [CLOSE_W-1:0] q_in;
        logic               hit_in;
        logic [MAG_W-1:0]   rem_next;
        logic [CLOSE_W-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign trial  = {1'b0, s4_n_reg};
            assign d_in   = s4_d_reg;
            assign q_in   = '0;
            assign hit_in = s4_hit_reg;
        end
        else
        begin : g_next
            assign trial  = {div_rem_reg[j-1], 1'b0};
            assign d_in   = div_d_reg[j-1];
            assign q_in   = div_q_reg[j-1];
            assign hit_in = div_hit_reg[j-1];
        end

        always_comb
        begin
            ge       = trial >= {1'b0, d_in};
            rem_next = ge ? MAG_W'(trial - {1'b0, d_in}) : trial[MAG_W-1:0];
            q_next   = {q_in[CLOSE_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[j] <= rem_next;
                div_d_reg[j]   <= d_in;
                div_q_reg[j]   <= q_next;
                div_hit_reg[j] <= hit_in;
            end
        end
    end

    assign result_valid     = div_valid_reg[NDIV-1];
    assign result.hit       = div_hit_reg[NDIV-1];
    assign result.closeness = div_hit_reg[NDIV-1] ? div_q_reg[NDIV-1] : '0;

    logic [NDIV+3:0] pipe_valid;
    assign pipe_valid = {div_valid_reg, s4_valid_reg, s3_valid_reg, s2_valid_reg, s1_valid_reg};

    `SIT_ASSERT(a_close_range, result_valid |-> (result.closeness <= (CLOSE_W'(1) << FRAC_BITS)), "closeness above one")
    `SIT_ASSERT(a_stall_cause, pair_stall |-> result_valid, "input stalled with no word waiting")
    `SIT_ASSERT(a_hold_valid, !adv |=> $stable(pipe_valid), "pipeline moved while stalled")
    `SIT_ASSERT_RST(a_reset_idle, !rst_n |-> !result_valid, "result valid during reset")

endmodule
